### hw/rtl/sha1e_pkg.sv
// ----------------------------------------------------------------------------
// sha1e_pkg
// Shared types and constants of the SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha1e_pkg;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    // one queued command from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       is_end;
    } sha1e_cmd_t;

endpackage

### hw/rtl/sha1e_ram.sv
// ----------------------------------------------------------------------------
// sha1e_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sha1e_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### hw/rtl/sha1e_front.sv
// ----------------------------------------------------------------------------
// sha1e_front
// Accepts input transactions, drops empty ones, queues commands for the core.
// ----------------------------------------------------------------------------
module sha1e_front #(
    parameter int QDEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 byte_present,
    input  logic                 end_of_message,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output sha1e_pkg::sha1e_cmd_t cmd
);
    import sha1e_pkg::*;

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    sha1e_cmd_t       q_mem [QDEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != (AW+1)'(QDEPTH));
    assign push      = in_valid && in_ready && (byte_present || end_of_message);
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{data: data_byte, has_byte: byte_present,
                                   is_end: end_of_message};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(QDEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(QDEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(QDEPTH)) else $error("queue overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> !push) else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0) else $error("pop from empty queue");
endmodule

### hw/rtl/sha1e_core.sv
// ----------------------------------------------------------------------------
// sha1e_core
// Byte packing, padding, 80-round compression and digest output.
// ----------------------------------------------------------------------------
module sha1e_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  sha1e_pkg::sha1e_cmd_t cmd,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           digest_word,
    output logic [2:0]            word_index,
    output logic                  last_word
);
    import sha1e_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LEN, S_LOAD, S_ROUND, S_ADD, S_OUT
    } state_t;

    state_t      state_reg;
    logic [5:0]  pos_reg;
    logic [63:0] bits_reg;
    logic [63:0] len_reg;
    logic        fin_reg;     // 0x80 pad byte already placed
    logic        pend_end_reg;// end request after byte placed
    logic [2:0]  len_cnt_reg;
    logic [6:0]  rnd_reg;
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] w_reg [16];
    logic [2:0]  oidx_reg;
    logic [23:0] acc_reg;
    logic [1:0]  bcnt_reg;

    // word RAM for the block: 16 x 32
    logic        wr_en;
    logic [3:0]  wr_addr, rd_addr;
    logic [31:0] wr_data, rd_data;

    sha1e_ram #(.WIDTH(32), .DEPTH(16)) u_blk (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // byte written this cycle by the packer
    logic       put;
    logic [7:0] put_byte;

    always_comb
    begin
        put      = 1'b0;
        put_byte = cmd.data;
        unique case (state_reg)
            S_IDLE:  begin put = cmd_ready && cmd_valid && cmd.has_byte; put_byte = cmd.data; end
            S_PAD:   begin put = 1'b1; put_byte = fin_reg ? 8'h00 : PAD_BYTE; end
            S_LEN:   begin put = 1'b1; put_byte = len_reg[63:56]; end
            default: begin put = 1'b0; end
        endcase
    end

    assign wr_en   = put && (pos_reg[1:0] == 2'd3);
    assign wr_addr = pos_reg[5:2];
    assign wr_data = {acc_reg, put_byte};
    assign cmd_ready = (state_reg == S_IDLE) && !pend_end_reg;

    // round logic
    logic [31:0] f, k, w_new, w_cur, t;
    always_comb
    begin
        w_new = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {w_new[30:0], w_new[31]};
        w_cur = (rnd_reg < 7'd16) ? rd_data : w_new;
        if (rnd_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg); k = K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg; k = K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg); k = K2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg; k = K3;
        end
        t = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + w_cur;
    end
    assign rd_addr = (state_reg == S_ROUND) ? rnd_reg[3:0] + 4'd1 : 4'd0;

    assign out_valid   = (state_reg == S_OUT);
    assign digest_word = h_reg[oidx_reg];
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == 3'd4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pos_reg      <= '0;
            bits_reg     <= '0;
            fin_reg      <= 1'b0;
            pend_end_reg <= 1'b0;
            h_reg        <= '{H0, H1, H2, H3, H4};
            oidx_reg     <= '0;
            rnd_reg      <= '0;
            len_cnt_reg  <= '0;
            bcnt_reg     <= '0;
        end
        else
        begin
            if (put)
            begin
                acc_reg <= {acc_reg[15:0], put_byte};
                pos_reg <= pos_reg + 6'd1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pend_end_reg)
                    begin
                        pend_end_reg <= 1'b0;
                        len_reg      <= bits_reg;
                        fin_reg      <= 1'b0;
                        state_reg    <= S_PAD;
                    end
                    else if (cmd_valid)
                    begin
                        if (cmd.has_byte)
                        begin
                            bits_reg <= bits_reg + 64'd8;
                            if (pos_reg == 6'd63)
                            begin
                                state_reg    <= S_LOAD;
                                pend_end_reg <= cmd.is_end;
                            end
                            else if (cmd.is_end)
                            begin
                                pend_end_reg <= 1'b1;
                            end
                        end
                        else if (cmd.is_end)
                        begin
                            pend_end_reg <= 1'b1;
                        end
                    end
                end
                S_PAD:
                begin
                    fin_reg <= 1'b1;
                    if (pos_reg == 6'd63)
                    begin
                        state_reg <= S_LOAD;
                    end
                    else if (pos_reg == 6'd55)
                    begin
                        state_reg   <= S_LEN;
                        len_cnt_reg <= '0;
                    end
                end
                S_LEN:
                begin
                    len_reg     <= {len_reg[55:0], 8'h00};
                    len_cnt_reg <= len_cnt_reg + 3'd1;
                    if (len_cnt_reg == 3'd7)
                    begin
                        state_reg <= S_LOAD;
                        bcnt_reg  <= 2'd1;
                    end
                end
                S_LOAD:
                begin
                    a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                    d_reg <= h_reg[3]; e_reg <= h_reg[4];
                    rnd_reg   <= '0;
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= w_reg[i+1];
                    end
                    w_reg[15] <= w_cur;
                    e_reg <= d_reg; d_reg <= c_reg;
                    c_reg <= {b_reg[1:0], b_reg[31:2]};
                    b_reg <= a_reg; a_reg <= t;
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == 7'd79)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    h_reg[0] <= h_reg[0] + a_reg; h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg; h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    if (bcnt_reg != 2'd0)
                    begin
                        bcnt_reg  <= '0;
                        oidx_reg  <= '0;
                        state_reg <= S_OUT;
                    end
                    else if (fin_reg)
                    begin
                        state_reg <= S_PAD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd4)
                        begin
                            state_reg <= S_IDLE;
                            h_reg     <= '{H0, H1, H2, H3, H4};
                            bits_reg  <= '0;
                            pos_reg   <= '0;
                            fin_reg   <= 1'b0;
                            oidx_reg  <= '0;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_out_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> oidx_reg <= 3'd4) else $error("digest index out of range");
    a_round_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROUND |-> pos_reg == 6'd0) else $error("block not full");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(oidx_reg))
        else $error("digest word dropped");
endmodule

### hw/rtl/sha1_hash_engine_unit.sv
// ----------------------------------------------------------------------------
// sha1_hash_engine_unit
// SHA-1 over a byte stream, digest as five 32-bit words.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one transaction carries an optional
// message byte and an optional end mark. Transactions with neither flag are
// consumed and dropped. A queue of QDEPTH entries (two by default)
// decouples the input from the core. Output channel (out_valid/out_ready):
// five transactions per message, digest_word with word_index 0..4,
// last_word on the fifth. Throughput: the core takes bytes while idle;
// each 64-byte block then runs the 80-round iterative compression (one
// round per cycle), during which no bytes are taken. End of message costs
// padding at one byte per cycle, one or two compressions, then five output
// transactions. Reset restores the initial chaining words and a zero length;
// no clearing pass is needed. When the receiver stalls, the core holds the
// digest word and the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module sha1_hash_engine_unit #(
    parameter int QDEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha1e_pkg::*;

    sha1e_cmd_t cmd;
    logic       cmd_valid, cmd_ready;

    sha1e_front #(.QDEPTH(QDEPTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .byte_present(byte_present),
        .end_of_message(end_of_message), .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready), .cmd(cmd)
    );

    sha1e_core u_core (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .cmd(cmd), .out_valid(out_valid), .out_ready(out_ready),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
    );
endmodule

### tb/sv/sha1_digest_checker.sv
// ----------------------------------------------------------------------------
// sha1_digest_checker
// Watches both channels of the SHA-1 engine, computes digests and compares.
// ----------------------------------------------------------------------------
module sha1_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int          fail_count,
    output int          pending_words
);
    import sha1e_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_txn_t;

    logic [31:0] chain [5];
    logic [7:0]  blk [64];
    int          blk_pos;
    logic [63:0] msg_bits;
    digest_txn_t digest_q [$];

    function automatic logic [31:0] rol(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic clear_hash();
        chain[0] = H0; chain[1] = H1; chain[2] = H2; chain[3] = H3; chain[4] = H4;
        blk_pos = 0;
        msg_bits = '0;
    endtask

    task automatic compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t, wt;
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 16)
                wt = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            else
                wt = rol(w[(i+13)&15] ^ w[(i+8)&15] ^ w[(i+2)&15] ^ w[i&15], 1);
            w[i&15] = wt;
            if (i < 20)
            begin
                f = (b & c) | (~b & d); k = K0;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d; k = K1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d); k = K2;
            end
            else
            begin
                f = b ^ c ^ d; k = K3;
            end
            t = rol(a, 5) + f + e + k + wt;
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endtask

    task automatic append(input logic [7:0] v);
        blk[blk_pos] = v;
        blk_pos = (blk_pos + 1) & 63;
        if (blk_pos == 0)
            compress();
    endtask

    task automatic absorb(input logic [7:0] v, input logic has_b, input logic fin);
        logic [63:0] len;
        digest_txn_t tx;
        if (has_b)
        begin
            append(v);
            msg_bits += 64'd8;
        end
        if (fin)
        begin
            len = msg_bits;
            append(PAD_BYTE);
            while (blk_pos != 56)
                append(8'h00);
            for (int i = 7; i >= 0; i--)
                append(len[8*i +: 8]);
            for (int i = 0; i < 5; i++)
            begin
                tx.word = chain[i];
                tx.idx = 3'(i);
                tx.last = (i == 4);
                digest_q.push_back(tx);
            end
            clear_hash();
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending_words = 0;
        clear_hash();
    end

    always @(posedge clk)
    begin
        digest_txn_t exp_tx;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                absorb(data_byte, byte_present, end_of_message);
            if (out_valid && out_ready)
            begin
                if (digest_q.size() == 0)
                    report("unexpected transaction", digest_word, 32'h0);
                else
                begin
                    exp_tx = digest_q.pop_front();
                    if (digest_word !== exp_tx.word)
                        report("digest_word", digest_word, exp_tx.word);
                    if (word_index !== exp_tx.idx)
                        report("word_index", 32'(word_index), 32'(exp_tx.idx));
                    if (last_word !== exp_tx.last)
                        report("last_word", 32'(last_word), 32'(exp_tx.last));
                end
            end
        end
        pending_words = digest_q.size();
    end
endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// SHA-1 engine testbench: directed and random messages with random idling.
// ----------------------------------------------------------------------------
module tb_top;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        end_of_message;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    int          fail_count;
    int          pending_words;
    int          cycle_count;
    int          n_sent;
    logic        hold_off;
    logic        drained;

    sha1_hash_engine_unit i_dut (.*);

    sha1_digest_checker i_chk (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    task automatic send(input logic [7:0] v, input logic has_b, input logic fin);
        int g;
        g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= v;
        byte_present <= has_b;
        end_of_message <= fin;
        // in_ready is sampled as it stood at the edge
        @(posedge clk iff in_ready);
        n_sent++;
    endtask

    task automatic send_message(input int n_bytes, input bit noisy);
        for (int i = 0; i < n_bytes; i++)
        begin
            if (noisy && $urandom_range(0, 7) == 0)
                send(8'($urandom), 1'b0, 1'b0);
            send(8'($urandom), 1'b1, (i == n_bytes - 1) && $urandom_range(0, 1));
        end
        if (!end_of_message || n_bytes == 0)
            send(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        byte_present = 1'b0;
        end_of_message = 1'b0;
        hold_off = 1'b0;
        drained = 1'b0;
        n_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send(8'h00, 1'b0, 1'b1);
        send(8'hFF, 1'b0, 1'b0);
        send(8'h00, 1'b1, 1'b0);
        send(8'hFF, 1'b1, 1'b1);
        send(8'h61, 1'b1, 1'b0);
        send(8'h62, 1'b1, 1'b0);
        send(8'h63, 1'b1, 1'b1);
        send(8'h55, 1'b1, 1'b0);
        send(8'hAA, 1'b0, 1'b0);
        send(8'hAA, 1'b1, 1'b0);
        send(8'h00, 1'b0, 1'b1);
        wait_drain();
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        send_message(64, 1'b0);
        wait_drain();
        hold_off <= 1'b1;
        send_message(6, 1'b0);
        send_message(3, 1'b0);
        hold_off <= 1'b0;
        wait_drain();
        while (n_sent < 210)
        begin
            case ($urandom_range(0, 9))
                0:       send(8'($urandom), 1'($urandom), 1'b0);
                default: send_message($urandom_range(0, 8), 1'b1);
            endcase
            if ($urandom_range(0, 5) == 0)
                wait_drain();
        end
        send(8'($urandom), 1'b0, 1'b1);
        wait_drain();
        repeat (100) @(posedge clk);
        drained = 1'b1;
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        cycle_count = 0;
        wait (drained || cycle_count >= 400000);
        if (drained)
        begin
            if (fail_count == 0)
                $display("No mismatches found");
            else
                $display("Mismatches found");
        end
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### sim.f
hw/rtl/sha1e_pkg.sv
hw/rtl/sha1e_ram.sv
hw/rtl/sha1e_front.sv
hw/rtl/sha1e_core.sv
hw/rtl/sha1_hash_engine_unit.sv
tb/sv/sha1_digest_checker.sv
tb/sv/tb_top.sv
